// ===== sv/spims_pkg.sv =====
// ----------------------------------------------------------------------------
// spims_pkg
// Shared constants and helpers for the SPI master shifter.
// ----------------------------------------------------------------------------
package spims_pkg;

    localparam int unsigned SLOW_HALF_PERIOD = 368;
    localparam int unsigned MAX_BYTES        = 4;

    localparam int unsigned DUR_W   = 8;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned COUNT_W = 3;
    localparam int unsigned DIV_W   = 9;
    localparam int unsigned EFF_W   = 4;

    localparam logic [DUR_W-1:0]   SLOW_MODE_MIN = 8'd4;
    localparam logic [EFF_W-1:0]   SLOW_EFF_CODE = 4'd12;
    localparam logic [COUNT_W-1:0] BYTES_MAX     = COUNT_W'(MAX_BYTES);

    localparam int unsigned S_TDATA_W = 40;
    localparam int unsigned M_TDATA_W = 16;

    typedef enum logic [0:0] {
        KIND_TICK  = 1'b0,
        KIND_START = 1'b1
    } kind_t;

    function automatic logic [DIV_W-1:0] half_period(input logic [DUR_W-1:0] dur);
        logic [DIV_W-1:0] hp;
        unique case (dur)
            8'd0:    hp = DIV_W'(2);
            8'd1:    hp = DIV_W'(8);
            8'd2:    hp = DIV_W'(32);
            8'd3:    hp = DIV_W'(64);
            default: hp = DIV_W'(SLOW_HALF_PERIOD);
        endcase
        return hp;
    endfunction

endpackage

// ===== sv/spi_master_shifter.sv =====
// ----------------------------------------------------------------------------
// spi_master_shifter
// SPI mode 0 master shifter, one stream word per system clock tick.
// ----------------------------------------------------------------------------
// Every input word is one tick of the SPI clock divider and shifter and
// produces exactly one output word; the block takes one word per cycle, with
// the state update done in the accept cycle and the result held in an output
// register so a stalled output blocks input only while that register is full.
// A start word (tuser = 1) while idle loads 1 to 4 bytes (larger counts saturate to 4), sent MSB first.
// cfg_data selects the SCK rate: 0..3 give dividers 4/16/64/128, 4 or more is
// slow mode (half period 368 ticks, MISO sampled at the falling edge).
module spi_master_shifter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,      // sck_duration
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [spims_pkg::S_TDATA_W-1:0] s_tdata, // tx_data[31:0], byte_count[34:32],
                                                     // miso[35], zero
    input  logic        s_tuser,       // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,       // sck, mosi, busy_res, rx_byte[10:3], eff_dur[14:11]
    output logic        m_tlast        // done_res
);

    logic [spims_pkg::DUR_W-1:0]   dur_reg;
    logic [spims_pkg::DATA_W-1:0]  shift_out_reg, shift_out_next;
    logic [7:0]                    shift_in_reg, shift_in_next;
    logic [7:0]                    last_rx_reg, last_rx_next;
    logic [2:0]                    bit_idx_reg, bit_idx_next;
    logic [spims_pkg::COUNT_W-1:0] bytes_left_reg, bytes_left_next;
    logic [spims_pkg::DIV_W-1:0]   div_reg, div_next;
    logic                          clk_lvl_reg, clk_lvl_next;
    logic                          active_reg, active_next;
    logic                          done_next;

    logic                          out_valid_reg;
    logic [spims_pkg::M_TDATA_W-1:0] out_data_reg, out_data_next;
    logic                          out_last_reg;

    logic                          accept;
    spims_pkg::kind_t              kind;
    logic [spims_pkg::DATA_W-1:0]  tx_data;
    logic [spims_pkg::COUNT_W-1:0] byte_count;
    logic [spims_pkg::COUNT_W-1:0] count_sat;
    logic                          miso;
    logic                          slow;
    logic [spims_pkg::DIV_W:0]     div_inc;
    logic [spims_pkg::EFF_W-1:0]   eff_dur;

    assign cfg_ready  = 1'b1;
    assign s_tready   = !out_valid_reg || m_tready;
    assign accept     = s_tvalid && s_tready;

    assign kind       = spims_pkg::kind_t'(s_tuser);
    assign tx_data    = s_tdata[31:0];
    assign byte_count = s_tdata[34:32];
    assign miso       = s_tdata[35];

    assign slow      = dur_reg >= spims_pkg::SLOW_MODE_MIN;
    assign count_sat = (byte_count > spims_pkg::BYTES_MAX) ? spims_pkg::BYTES_MAX : byte_count;
    assign div_inc   = {1'b0, div_reg} + (spims_pkg::DIV_W + 1)'(1);
    assign eff_dur   = slow ? spims_pkg::SLOW_EFF_CODE : dur_reg[spims_pkg::EFF_W-1:0];

    always_comb begin
        shift_out_next  = shift_out_reg;
        shift_in_next   = shift_in_reg;
        last_rx_next    = last_rx_reg;
        bit_idx_next    = bit_idx_reg;
        bytes_left_next = bytes_left_reg;
        div_next        = div_reg;
        clk_lvl_next    = clk_lvl_reg;
        active_next     = active_reg;
        done_next       = 1'b0;
        if (!active_reg) begin
            if (kind == spims_pkg::KIND_START && byte_count != '0) begin
                unique case (count_sat)
                    3'd1:    shift_out_next = {tx_data[7:0], 24'd0};
                    3'd2:    shift_out_next = {tx_data[15:0], 16'd0};
                    3'd3:    shift_out_next = {tx_data[23:0], 8'd0};
                    default: shift_out_next = tx_data;
                endcase
                shift_in_next   = '0;
                bit_idx_next    = 3'd7;
                bytes_left_next = count_sat;
                div_next        = '0;
                clk_lvl_next    = 1'b0;
                active_next     = 1'b1;
            end
        end else if (div_inc >= {1'b0, spims_pkg::half_period(dur_reg)}) begin
            div_next = '0;
            if (!clk_lvl_reg) begin
                clk_lvl_next = 1'b1;
                if (!slow) begin
                    shift_in_next = {shift_in_reg[6:0], miso};
                end
            end else begin
                clk_lvl_next = 1'b0;
                if (slow) begin
                    shift_in_next = {shift_in_reg[6:0], miso};
                end
                shift_out_next = {shift_out_reg[spims_pkg::DATA_W-2:0], 1'b0};
                if (bit_idx_reg == 3'd0) begin
                    last_rx_next    = shift_in_next;
                    bit_idx_next    = 3'd7;
                    bytes_left_next = bytes_left_reg - spims_pkg::COUNT_W'(1);
                    if (bytes_left_next == '0) begin
                        active_next = 1'b0;
                        done_next   = 1'b1;
                    end
                end else begin
                    bit_idx_next = bit_idx_reg - 3'd1;
                end
            end
        end else begin
            div_next = div_inc[spims_pkg::DIV_W-1:0];
        end
    end

    always_comb begin
        out_data_next = {1'b0, eff_dur, last_rx_next, active_next,
                         active_next & shift_out_next[spims_pkg::DATA_W-1], clk_lvl_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dur_reg        <= 8'd1;
            shift_out_reg  <= '0;
            shift_in_reg   <= '0;
            last_rx_reg    <= '0;
            bit_idx_reg    <= 3'd7;
            bytes_left_reg <= '0;
            div_reg        <= '0;
            clk_lvl_reg    <= 1'b0;
            active_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                dur_reg <= cfg_data;
            end
            if (accept) begin
                shift_out_reg  <= shift_out_next;
                shift_in_reg   <= shift_in_next;
                last_rx_reg    <= last_rx_next;
                bit_idx_reg    <= bit_idx_next;
                bytes_left_reg <= bytes_left_next;
                div_reg        <= div_next;
                clk_lvl_reg    <= clk_lvl_next;
                active_reg     <= active_next;
                out_valid_reg  <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_data_reg <= out_data_next;
            out_last_reg <= done_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> !m_tdata[2])
        else $error("done reported while still busy");

    a_mosi_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[2] |-> !m_tdata[1])
        else $error("mosi high while idle");

    a_idle_no_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        !active_reg |-> bytes_left_reg == '0)
        else $error("bytes left while idle");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && !s_tready || m_tready)
        else $error("input taken while output stalled");

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the SPI mode 0 master shifter.
// ----------------------------------------------------------------------------
// Each word sent in is one tick of the shifter. A behavioral copy of the
// shifter runs on every accepted input word and queues the pin levels and
// status it should report; the output monitor compares each returned word
// against the oldest queued one. Rate changes are made between phases while
// the stream is drained, some of them in the middle of a transfer.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned RANDOM_TICKS = 1200;
    localparam int unsigned TAIL_TICKS   = 150;

    typedef struct {
        spims_pkg::kind_t              kind;
        logic [spims_pkg::DATA_W-1:0]  tx;
        logic [spims_pkg::COUNT_W-1:0] cnt;
        logic                          miso;
    } tick_word_t;

    typedef struct {
        logic                        sck;
        logic                        mosi;
        logic                        busy;
        logic                        done;
        logic [7:0]                  rx;
        logic [spims_pkg::EFF_W-1:0] eff;
    } pin_view_t;

    logic                        aclk      = 1'b0;
    logic                        aresetn   = 1'b0;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [spims_pkg::DUR_W-1:0] cfg_data  = '0;
    logic                        s_tvalid  = 1'b0;
    logic                        s_tready;
    logic [39:0]       s_tdata   = '0;  // tx_data[31:0], byte_count[34:32], miso[35], zero
    logic              s_tuser   = 1'b0; // kind
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [15:0]       m_tdata;         // sck, mosi, busy, rx_byte[10:3], eff_dur[14:11]
    logic              m_tlast;         // done

    tick_word_t  tick_q[$];
    pin_view_t   pin_view_q[$];
    tick_word_t  on_bus;
    bit          idling_en  = 1'b1;
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;
    int unsigned send_gap   = 0;
    int unsigned recv_stall = 0;

    // shifter image
    logic [spims_pkg::DUR_W-1:0]   dur_reg   = 8'd1;
    logic [spims_pkg::DATA_W-1:0]  out_sr    = '0;
    logic [7:0]                    in_sr     = '0;
    logic [7:0]                    rx_last   = '0;
    logic [2:0]                    bit_pos   = 3'd7;
    logic [spims_pkg::COUNT_W-1:0] bytes_rem = '0;
    logic [spims_pkg::DIV_W-1:0]   div_cnt   = '0;
    logic                          sck_lvl   = 1'b0;
    logic                          xfer_on   = 1'b0;

    spi_master_shifter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic pin_view_t advance_spi(tick_word_t w);
        pin_view_t                   v;
        logic [spims_pkg::DIV_W-1:0] hp;
        logic [2:0]                  n;
        bit                          slow;
        int unsigned                 nxt;
        slow = (dur_reg >= spims_pkg::SLOW_MODE_MIN);
        case (dur_reg)
            8'd0:    hp = spims_pkg::DIV_W'(2);
            8'd1:    hp = spims_pkg::DIV_W'(8);
            8'd2:    hp = spims_pkg::DIV_W'(32);
            8'd3:    hp = spims_pkg::DIV_W'(64);
            default: hp = spims_pkg::DIV_W'(spims_pkg::SLOW_HALF_PERIOD);
        endcase
        v.done = 1'b0;
        if (!xfer_on) begin
            if (w.kind == spims_pkg::KIND_START && w.cnt != 0) begin
                n = (w.cnt > spims_pkg::MAX_BYTES) ? 3'(spims_pkg::MAX_BYTES) : w.cnt;
                out_sr    = w.tx << (8 * (4 - n));
                in_sr     = '0;
                bit_pos   = 3'd7;
                bytes_rem = n;
                div_cnt   = '0;
                sck_lvl   = 1'b0;
                xfer_on   = 1'b1;
            end
        end else begin
            nxt = div_cnt + 1;
            if (nxt >= hp) begin
                div_cnt = '0;
                if (!sck_lvl) begin
                    sck_lvl = 1'b1;
                    if (!slow) in_sr = {in_sr[6:0], w.miso};
                end else begin
                    sck_lvl = 1'b0;
                    if (slow) in_sr = {in_sr[6:0], w.miso};
                    out_sr = out_sr << 1;
                    if (bit_pos == 0) begin
                        rx_last   = in_sr;
                        bit_pos   = 3'd7;
                        bytes_rem = bytes_rem - spims_pkg::COUNT_W'(1);
                        if (bytes_rem == 0) begin
                            xfer_on = 1'b0;
                            v.done  = 1'b1;
                        end
                    end else begin
                        bit_pos = bit_pos - 3'd1;
                    end
                end
            end else begin
                div_cnt = nxt[spims_pkg::DIV_W-1:0];
            end
        end
        v.sck  = sck_lvl;
        v.mosi = xfer_on ? out_sr[31] : 1'b0;
        v.busy = xfer_on;
        v.rx   = rx_last;
        v.eff  = slow ? spims_pkg::SLOW_EFF_CODE : dur_reg[spims_pkg::EFF_W-1:0];
        return v;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_tvalid && s_tready) pin_view_q.push_back(advance_spi(on_bus));
            if (s_tvalid && !s_tready) begin
                s_tvalid <= 1'b1;
            end else if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (tick_q.size() > 0 && idling_en && $urandom_range(0, 9) == 0) begin
                send_gap = $urandom_range(0, 15);
                s_tvalid <= 1'b0;
            end else if (tick_q.size() > 0) begin
                on_bus = tick_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {4'b0, on_bus.miso, on_bus.cnt, on_bus.tx};
                s_tuser  <= on_bus.kind;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // output monitor
    always @(posedge aclk) begin
        pin_view_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pin_view_q.size() == 0) begin
                    $error("unexpected output word %h last %b", m_tdata, m_tlast);
                    fail_count++;
                end else begin
                    want = pin_view_q.pop_front();
                    check_field("sck", want.sck, m_tdata[0]);
                    check_field("mosi", want.mosi, m_tdata[1]);
                    check_field("busy", want.busy, m_tdata[2]);
                    check_field("done", want.done, m_tlast);
                    check_field("rx_byte", want.rx, m_tdata[10:3]);
                    check_field("effective_duration", want.eff, m_tdata[14:11]);
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
                m_tready <= 1'b0;
            end else if (idling_en && $urandom_range(0, 9) == 0) begin
                recv_stall = $urandom_range(0, 15);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic tick_word_t mk_tick(spims_pkg::kind_t k, logic [31:0] tx,
                                           logic [2:0] c, logic mi);
        tick_word_t w;
        w.kind = k;
        w.tx   = tx;
        w.cnt  = c;
        w.miso = mi;
        return w;
    endfunction

    function automatic tick_word_t random_tick();
        tick_word_t  w;
        int unsigned r;
        w.kind = ($urandom_range(0, 15) == 0) ? spims_pkg::KIND_START : spims_pkg::KIND_TICK;
        w.tx   = $urandom();
        w.miso = 1'($urandom_range(0, 1));
        r = $urandom_range(0, 9);
        if (r < 6)
            w.cnt = 3'd1 << $urandom_range(0, 2);
        else if (r < 9)
            w.cnt = 3'($urandom_range(3, 7));
        else
            w.cnt = 3'd0;
        return w;
    endfunction

    task automatic wait_drained();
        while (tick_q.size() != 0 || s_tvalid || pin_view_q.size() != 0)
            @(posedge aclk);
    endtask

    task automatic set_duration(input logic [spims_pkg::DUR_W-1:0] val);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        dur_reg = val;
    endtask

    task automatic push_random(input int unsigned n);
        repeat (n) tick_q.push_back(random_tick());
    endtask

    initial begin
        int unsigned sent;
        int unsigned len;
        int unsigned r;
        logic [spims_pkg::DUR_W-1:0] dur;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // idle tick, ignored start, saturated start, start while busy
        tick_q.push_back(mk_tick(spims_pkg::KIND_TICK, '1, 3'd7, 1'b1));
        tick_q.push_back(mk_tick(spims_pkg::KIND_START, '1, 3'd0, 1'b1));
        tick_q.push_back(mk_tick(spims_pkg::KIND_START, '1, 3'd7, 1'b1));
        tick_q.push_back(mk_tick(spims_pkg::KIND_START, '0, 3'd1, 1'b0));
        repeat (4) tick_q.push_back(mk_tick(spims_pkg::KIND_TICK, '0, 3'd0, 1'b0));
        // rate changes mid-transfer, divider already past the new half period
        set_duration(8'd0);
        repeat (3) tick_q.push_back(mk_tick(spims_pkg::KIND_TICK, 32'h5a5a_a5a5, 3'd2, 1'b1));
        set_duration(8'hff);
        repeat (3) tick_q.push_back(mk_tick(spims_pkg::KIND_TICK, '0, 3'd4, 1'b0));
        set_duration(spims_pkg::SLOW_MODE_MIN);
        repeat (2) tick_q.push_back(mk_tick(spims_pkg::KIND_TICK, '1, 3'd4, 1'b1));
        set_duration(8'd3);
        repeat (2) tick_q.push_back(mk_tick(spims_pkg::KIND_TICK, '0, 3'd3, 1'b0));
        set_duration(8'd2);
        repeat (2) tick_q.push_back(mk_tick(spims_pkg::KIND_TICK, '1, 3'd5, 1'b1));

        sent = 0;
        while (sent < RANDOM_TICKS) begin
            if (RANDOM_TICKS - sent <= TAIL_TICKS) begin
                idling_en = 1'b0;
                set_duration(8'd0);
                len = RANDOM_TICKS - sent;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 60) dur = 8'd0;
                else if (r < 75) dur = 8'd1;
                else if (r < 83) dur = 8'd2;
                else if (r < 88) dur = 8'd3;
                else dur = 8'($urandom_range(4, 255));
                set_duration(dur);
                idling_en = ($urandom_range(0, 3) != 0);
                len = (dur >= spims_pkg::SLOW_MODE_MIN) ? $urandom_range(20, 400)
                                                        : $urandom_range(8, 120);
                if (len > RANDOM_TICKS - TAIL_TICKS - sent)
                    len = RANDOM_TICKS - TAIL_TICKS - sent;
            end
            push_random(len);
            sent += len;
        end

        wait_drained();
        repeat (20) @(posedge aclk);
        if (fail_count == 0 && pin_view_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
